// ----- rtl/salc_pkg.sv -----
// types and constants for the size-aware lru cache core
// used by salc_ctrl, salc_dp and size_aware_lru_cache_core
`default_nettype none
package salc_pkg;
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_BIG     = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic [31:0] CAP_RESET = 32'd1048576;

  typedef struct packed {
    logic        opcode;
    logic [31:0] obj_id;
    logic [31:0] obj_size;
  } in_word_t;

  typedef struct packed {
    logic        is_last;
    logic        is_eviction;
    logic [31:0] evicted_id;
    logic [31:0] evicted_size;
    logic        hit;
    logic [1:0]  status;
    logic [31:0] used_bytes_out;
  } out_word_t;

  // datapath commands, one-hot per step
  typedef struct packed {
    logic load;     // capture input word
    logic lookup;   // register match index and hit flag
    logic drop_hit; // remove the matched entry
    logic touch;    // update size and rank of the matched entry
    logic evict;    // drop oldest entry, log its report
    logic insert;   // write the new entry at the free slot
    logic pop;      // fetch the next logged eviction report
  } dp_cmd_t;

  typedef struct packed {
    logic       opcode;
    logic       hit;
    logic       size_zero;
    logic       too_big;
    logic       full;
    logic       over;   // used bytes above capacity
    logic       any_live;
    logic       log_more; // eviction reports still to send
  } dp_stat_t;
endpackage
`default_nettype wire

// ----- rtl/salc_dp.sv -----
// datapath: slot table, byte count, rank tracking and result fields
// depends on salc_pkg
`default_nettype none
module salc_dp import salc_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire in_word_t in_w,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  output logic [31:0]   ev_id,
  output logic [31:0]   ev_size,
  output logic [31:0]   used_low
);
  localparam int IW = $clog2(SLOTS);
  localparam int RW = $clog2(SLOTS + 1);

  logic [31:0] capacity;
  in_word_t    cur;
  logic [SLOTS-1:0] valid;
  logic [31:0] key   [SLOTS];
  logic [31:0] bytes [SLOTS];
  logic [RW-1:0] rank [SLOTS];
  logic [32:0] used;
  logic [RW-1:0] live;

  // eviction reports of the current item, sent once the byte count is final
  logic [31:0]   log_id   [SLOTS];
  logic [31:0]   log_size [SLOTS];
  logic [RW-1:0] wr_ptr, rd_ptr;

  logic [SLOTS-1:0] match_vec, free_vec, old_vec;
  logic [IW-1:0] match_idx, free_idx, old_idx;
  logic          hit, has_free;

  always_comb begin
    match_vec = '0;
    free_vec  = '0;
    old_vec   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = valid[i] && key[i] == cur.obj_id;
      free_vec[i]  = !valid[i];
      old_vec[i]   = valid[i] && rank[i] == live - RW'(1);
    end
  end

  always_comb begin
    free_idx = '0;
    has_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = IW'(i);
        has_free = 1'b1;
      end
    end
  end

  always_comb begin
    match_idx = '0;
    old_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match_vec[i]) match_idx = IW'(i);
      if (old_vec[i])   old_idx   = IW'(i);
    end
  end
  assign hit = |match_vec;

  // registered search result
  logic [IW-1:0] m_idx;
  always_ff @(posedge clk) begin
    if (cmd.lookup) m_idx <= match_idx;
  end

  logic [32:0] sub_hit, sub_old;
  assign sub_hit = (used >= {1'b0, bytes[m_idx]}) ? used - {1'b0, bytes[m_idx]} : '0;
  assign sub_old = (used >= {1'b0, bytes[old_idx]}) ? used - {1'b0, bytes[old_idx]} : '0;

  logic hit_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      valid    <= '0;
      used     <= '0;
      live     <= '0;
      hit_r    <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (cmd.load) begin
        cur    <= in_w;
        wr_ptr <= '0;
        rd_ptr <= '0;
      end
      if (cmd.lookup) hit_r <= hit;
      if (cmd.drop_hit) begin
        valid[m_idx] <= 1'b0;
        used <= sub_hit;
        live <= live - RW'(1);
        for (int i = 0; i < SLOTS; i++)
          if (valid[i] && rank[i] > rank[m_idx]) rank[i] <= rank[i] - RW'(1);
      end
      if (cmd.touch) begin
        used <= sub_hit + {1'b0, cur.obj_size};
        bytes[m_idx] <= cur.obj_size;
        for (int i = 0; i < SLOTS; i++)
          if (valid[i] && rank[i] < rank[m_idx]) rank[i] <= rank[i] + RW'(1);
        rank[m_idx] <= '0;
      end
      if (cmd.evict) begin
        log_id[wr_ptr[IW-1:0]]   <= key[old_idx];
        log_size[wr_ptr[IW-1:0]] <= bytes[old_idx];
        wr_ptr <= wr_ptr + RW'(1);
        valid[old_idx] <= 1'b0;
        used <= sub_old;
        live <= live - RW'(1);
      end
      if (cmd.pop) begin
        ev_id   <= log_id[rd_ptr[IW-1:0]];
        ev_size <= log_size[rd_ptr[IW-1:0]];
        rd_ptr  <= rd_ptr + RW'(1);
      end
      if (cmd.insert) begin
        for (int i = 0; i < SLOTS; i++)
          if (valid[i]) rank[i] <= rank[i] + RW'(1);
        valid[free_idx] <= 1'b1;
        key[free_idx]   <= cur.obj_id;
        bytes[free_idx] <= cur.obj_size;
        rank[free_idx]  <= '0;
        used <= used + {1'b0, cur.obj_size};
        live <= live + RW'(1);
      end
    end
  end

  assign stat.opcode    = cur.opcode;
  assign stat.hit       = hit_r;
  assign stat.size_zero = cur.obj_size == '0;
  assign stat.too_big   = cur.obj_size > capacity;
  assign stat.full      = !has_free;
  assign stat.over      = used > {1'b0, capacity};
  assign stat.any_live  = live != '0;
  assign stat.log_more  = rd_ptr != wr_ptr;
  assign used_low       = used[31:0];
endmodule
`default_nettype wire

// ----- rtl/salc_ctrl.sv -----
// controller: sequences lookup, update, evictions and the summary word
// depends on salc_pkg
`default_nettype none
module salc_ctrl import salc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          o_valid,
  output logic          o_last,
  output logic [1:0]    o_status,
  input  wire logic     out_stall
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_EVO  = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] status, status_next;

  assign in_stall = state != S_IDLE;
  assign o_valid  = state == S_EVO || state == S_SUM;
  assign o_last   = state == S_SUM;
  assign o_status = status;

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        status_next = ST_OK;
        if (stat.opcode == OP_REMOVE) begin
          if (stat.hit) cmd.drop_hit = 1'b1;
          else status_next = ST_MISSING;
          state_next = S_SUM;
        end else if (stat.size_zero) begin
          status_next = ST_ZERO;
          state_next = S_SUM;
        end else if (stat.too_big) begin
          status_next = ST_BIG;
          state_next = S_SUM;
        end else if (stat.hit) begin
          cmd.touch = 1'b1;
          state_next = S_CHK;
        end else if (stat.full) begin
          // full table: free the oldest slot, then insert
          cmd.evict = 1'b1;
          state_next = S_INS;
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_next = S_CHK;
      end
      // evict one per cycle until within budget or no entry is left, then send the logged reports
      S_CHK: begin
        if (stat.over && stat.any_live) begin
          cmd.evict = 1'b1;
        end else if (stat.log_more) begin
          cmd.pop = 1'b1;
          state_next = S_EVO;
        end else begin
          state_next = S_SUM;
        end
      end
      // eviction word held until taken
      S_EVO: if (!out_stall) begin
        if (stat.log_more) cmd.pop = 1'b1;
        else state_next = S_SUM;
      end
      S_SUM: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_OK;
    end else begin
      status <= status_next;
      state  <= state_next;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/size_aware_lru_cache_core.sv -----
// top level of the size-aware lru cache core
// depends on salc_pkg, salc_ctrl, salc_dp
//
// channel | direction | handshake             | word
// in      | input     | in_valid / in_stall   | in_word_t
// out     | output    | out_valid / out_stall | out_word_t
//
// an item steps through load, lookup and decision; an insert then writes its entry
// and a hit or insert evicts while over budget before the eviction and summary words
// evictions are logged first so every word carries the final byte count
// rst is synchronous, clears valid bits and byte count, restores the capacity
// in_stall is high from acceptance until the summary word is taken
`default_nettype none
module size_aware_lru_cache_core import salc_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data
);
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] ev_id, ev_size, used_low;
  logic        o_last;
  logic [1:0]  o_status;

  salc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .stat, .cmd,
    .o_valid(out_valid), .o_last, .o_status, .out_stall
  );

  salc_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .in_w(in_data), .cmd, .stat,
    .ev_id, .ev_size, .used_low
  );

  always_comb begin
    out_data.is_last        = o_last;
    out_data.is_eviction    = !o_last;
    out_data.evicted_id     = o_last ? 32'd0 : ev_id;
    out_data.evicted_size   = o_last ? 32'd0 : ev_size;
    out_data.hit            = stat.hit;
    out_data.status         = o_status;
    out_data.used_bytes_out = used_low;
  end
endmodule
`default_nettype wire
